>>> src/tbgc_pkg.sv
// Shared types and constants for the two-button gesture combiner.
// Used by tbgc_step, two_button_gesture_combiner_core and the testbench; no dependencies.
package tbgc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned FUNC_W = 3;
    localparam int unsigned CODE_W = 4;

    localparam logic [CFG_W-1:0] HOLD_THRESHOLD_RESET = 16'd2000;
    localparam logic [CFG_W-1:0] CUE_COOLDOWN_RESET = 16'd300;

    // Configuration register indexes.
    localparam logic CFG_IDX_HOLD_THRESHOLD = 1'b0;
    localparam logic CFG_IDX_CUE_COOLDOWN = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_DOWN = 3'd0,
        FN_UP = 3'd1,
        FN_CLICK = 3'd2,
        FN_LONG_START = 3'd3,
        FN_LONG_RELEASE = 3'd4,
        FN_TIMER = 3'd5
    } func_t;

    typedef enum logic [CODE_W-1:0] {
        EV_LDOWN = 4'd0,
        EV_LUP = 4'd1,
        EV_RDOWN = 4'd2,
        EV_RUP = 4'd3,
        EV_LPRESS = 4'd4,
        EV_RPRESS = 4'd5,
        EV_LHOLD = 4'd6,
        EV_RHOLD = 4'd7,
        EV_BOTH_DOWN = 4'd8,
        EV_BOTH_HOLD = 4'd9,
        EV_BOTH_UP = 4'd10
    } event_t;

    typedef struct packed {
        logic left_down;
        logic right_down;
        logic both_seen;
        logic [TIME_W-1:0] left_cue_time;
        logic [TIME_W-1:0] right_cue_time;
        logic hold_timer_running;
        logic [TIME_W-1:0] hold_timer_start;
    } gest_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] hold_threshold_ms;
        logic [CFG_W-1:0] cue_cooldown_ms;
    } cfg_t;

    // At most two results come from one request.
    typedef struct packed {
        logic [1:0] count;
        event_t code0;
        event_t code1;
    } step_res_t;

endpackage

>>> src/tbgc_step.sv
// Combinational step of the gesture combiner: next state and up to two codes.
// Depends on tbgc_pkg.
module tbgc_step (
    input  tbgc_pkg::gest_state_t cur,
    input  tbgc_pkg::cfg_t cfg,
    input  logic [tbgc_pkg::FUNC_W-1:0] func,
    input  logic side,
    input  logic [tbgc_pkg::TIME_W-1:0] now_ms,
    output tbgc_pkg::gest_state_t nxt,
    output tbgc_pkg::step_res_t res
);

    logic is_left;
    logic [tbgc_pkg::TIME_W-1:0] stamp;
    logic cue_ok;
    logic timer_expired;
    logic both_now;
    tbgc_pkg::event_t press_code;

    assign is_left = ~side;
    assign stamp = is_left ? cur.left_cue_time : cur.right_cue_time;
    // A zero stamp means no cue has been given yet.
    assign cue_ok = (stamp == '0)
        || ((now_ms - stamp) >= {{(tbgc_pkg::TIME_W-tbgc_pkg::CFG_W){1'b0}},
            cfg.cue_cooldown_ms});
    assign timer_expired = (now_ms - cur.hold_timer_start)
        >= {{(tbgc_pkg::TIME_W-tbgc_pkg::CFG_W){1'b0}}, cfg.hold_threshold_ms};
    assign press_code = is_left ? tbgc_pkg::EV_LPRESS : tbgc_pkg::EV_RPRESS;
    assign both_now = (is_left | cur.left_down) & (~is_left | cur.right_down);

    always_comb
    begin
        nxt = cur;
        res.count = 2'd0;
        res.code0 = tbgc_pkg::EV_LDOWN;
        res.code1 = tbgc_pkg::EV_LDOWN;
        unique case (func)
            tbgc_pkg::FN_DOWN:
            begin
                if (is_left)
                begin
                    nxt.left_down = 1'b1;
                    res.code0 = tbgc_pkg::EV_LDOWN;
                end
                else
                begin
                    nxt.right_down = 1'b1;
                    res.code0 = tbgc_pkg::EV_RDOWN;
                end
                res.count = 2'd1;
                if (both_now)
                begin
                    if (!cur.both_seen)
                    begin
                        res.code1 = tbgc_pkg::EV_BOTH_DOWN;
                        res.count = 2'd2;
                        nxt.both_seen = 1'b1;
                    end
                    if (!cur.hold_timer_running)
                    begin
                        nxt.hold_timer_running = 1'b1;
                        nxt.hold_timer_start = now_ms;
                    end
                end
                else
                begin
                    if (cue_ok)
                    begin
                        if (is_left)
                            nxt.left_cue_time = now_ms;
                        else
                            nxt.right_cue_time = now_ms;
                        res.code1 = press_code;
                        res.count = 2'd2;
                    end
                    nxt.hold_timer_running = 1'b0;
                    nxt.both_seen = 1'b0;
                end
            end
            tbgc_pkg::FN_UP, tbgc_pkg::FN_LONG_RELEASE:
            begin
                if (is_left)
                    nxt.left_down = 1'b0;
                else
                    nxt.right_down = 1'b0;
                nxt.hold_timer_running = 1'b0;
                nxt.both_seen = 1'b0;
                if (func == tbgc_pkg::FN_UP)
                begin
                    res.code0 = is_left ? tbgc_pkg::EV_LUP : tbgc_pkg::EV_RUP;
                    res.count = 2'd1;
                end
                // Both released after a both-held down event closes the gesture.
                if (!nxt.left_down && !nxt.right_down && cur.both_seen)
                begin
                    if (func == tbgc_pkg::FN_UP)
                    begin
                        res.code1 = tbgc_pkg::EV_BOTH_UP;
                        res.count = 2'd2;
                    end
                    else
                    begin
                        res.code0 = tbgc_pkg::EV_BOTH_UP;
                        res.count = 2'd1;
                    end
                end
            end
            tbgc_pkg::FN_CLICK:
            begin
                if (cue_ok)
                begin
                    if (is_left)
                        nxt.left_cue_time = now_ms;
                    else
                        nxt.right_cue_time = now_ms;
                    res.code0 = press_code;
                    res.count = 2'd1;
                end
            end
            tbgc_pkg::FN_LONG_START:
            begin
                if (is_left ? cur.right_down : cur.left_down)
                begin
                    if (!cur.hold_timer_running)
                    begin
                        nxt.hold_timer_running = 1'b1;
                        nxt.hold_timer_start = now_ms;
                    end
                end
                else
                begin
                    res.code0 = is_left ? tbgc_pkg::EV_LHOLD : tbgc_pkg::EV_RHOLD;
                    res.count = 2'd1;
                end
            end
            tbgc_pkg::FN_TIMER:
            begin
                if (cur.hold_timer_running && timer_expired)
                begin
                    nxt.hold_timer_running = 1'b0;
                    if (cur.left_down && cur.right_down && cur.both_seen)
                    begin
                        res.code0 = tbgc_pkg::EV_BOTH_HOLD;
                        res.count = 2'd1;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> src/two_button_gesture_combiner_core.sv
// A request accepted into the input register is evaluated by tbgc_step, and its results
// are loaded into the result register once that register is free.
// One request per cycle while the output side does not stall; a request with two results
// presents them one after the other, and a following request with results waits behind it.
// Reset (rst_n, asynchronous, active low) clears all flags, stamps and the
// timer, and loads the threshold and cooldown registers with 2000 and 300.
// Top level of the gesture combiner; depends on tbgc_pkg and tbgc_step.
module two_button_gesture_combiner_core (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic cfg_index,
    input  logic [tbgc_pkg::CFG_W-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic [tbgc_pkg::FUNC_W-1:0] func,
    input  logic side,
    input  logic [tbgc_pkg::TIME_W-1:0] now_ms,
    output logic out_valid,
    input  logic out_stall,
    output logic [tbgc_pkg::CODE_W-1:0] event_code,
    output logic left_held,
    output logic right_held,
    output logic last
);

    tbgc_pkg::cfg_t cfg_reg;
    tbgc_pkg::gest_state_t state_reg;
    tbgc_pkg::gest_state_t state_next;
    tbgc_pkg::step_res_t step_res;

    logic pipe_valid_reg;
    logic [tbgc_pkg::FUNC_W-1:0] pipe_func_reg;
    logic pipe_side_reg;
    logic [tbgc_pkg::TIME_W-1:0] pipe_now_reg;

    logic [1:0] res_cnt_reg;
    logic [1:0] res_cnt_next;
    tbgc_pkg::event_t code0_reg;
    tbgc_pkg::event_t code1_reg;
    logic left_held_reg;
    logic right_held_reg;

    logic in_acc;
    logic out_acc;
    logic res_free;
    logic advance;
    logic load_res;

    tbgc_step u_step (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .func   (pipe_func_reg),
        .side   (pipe_side_reg),
        .now_ms (pipe_now_reg),
        .nxt    (state_next),
        .res    (step_res)
    );

    assign out_valid = (res_cnt_reg != 2'd0);
    assign out_acc = out_valid && !out_stall;
    assign res_free = (res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && out_acc);
    // A request without results never waits for the output side.
    assign advance = pipe_valid_reg && ((step_res.count == 2'd0) || res_free);
    assign load_res = advance && (step_res.count != 2'd0);
    assign in_stall = pipe_valid_reg && !advance;
    assign in_acc = in_valid && !in_stall;

    assign event_code = code0_reg;
    assign left_held = left_held_reg;
    assign right_held = right_held_reg;
    assign last = (res_cnt_reg == 2'd1);

    always_comb
    begin
        priority if (load_res)
            res_cnt_next = step_res.count;
        else if (out_acc)
            res_cnt_next = res_cnt_reg - 2'd1;
        else
            res_cnt_next = res_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_threshold_ms <= tbgc_pkg::HOLD_THRESHOLD_RESET;
            cfg_reg.cue_cooldown_ms <= tbgc_pkg::CUE_COOLDOWN_RESET;
            state_reg <= '0;
            pipe_valid_reg <= 1'b0;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    tbgc_pkg::CFG_IDX_HOLD_THRESHOLD:
                        cfg_reg.hold_threshold_ms <= cfg_data;
                    tbgc_pkg::CFG_IDX_CUE_COOLDOWN:
                        cfg_reg.cue_cooldown_ms <= cfg_data;
                    default:
                        cfg_reg <= cfg_reg;
                endcase
            end
            if (advance)
                state_reg <= state_next;
            if (in_acc)
                pipe_valid_reg <= 1'b1;
            else if (advance)
                pipe_valid_reg <= 1'b0;
            res_cnt_reg <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            pipe_func_reg <= func;
            pipe_side_reg <= side;
            pipe_now_reg <= now_ms;
        end
        if (load_res)
        begin
            code0_reg <= step_res.code0;
            code1_reg <= step_res.code1;
            left_held_reg <= state_next.left_down;
            right_held_reg <= state_next.right_down;
        end
        else if (out_acc)
        begin
            code0_reg <= code1_reg;
        end
    end

    // The result buffer holds two codes at most.
    assert property (@(posedge clk) disable iff (!rst_n) res_cnt_reg != 2'd3)
        else $error("result count out of range");

    // The both-held flag is only ever set while both buttons are pressed.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.both_seen |-> (state_reg.left_down && state_reg.right_down))
        else $error("both_seen set without both buttons pressed");

    // A full result buffer drains one code at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt_reg == 2'd2) |=> (res_cnt_reg != 2'd0))
        else $error("result buffer lost a code");

    // The input register only stalls while it holds a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> pipe_valid_reg)
        else $error("input register emptied while stalled");

endmodule

>>> tb/gesture_checker.sv
// Checker for the two-button gesture combiner: watches the configuration port and both
// channels, predicts the gesture codes of every accepted request and compares them.
// Depends on tbgc_pkg for the field widths, request functions and event codes.
module gesture_checker
    import tbgc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_wr_en,
    input  logic cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic in_valid,
    input  logic in_stall,
    input  logic [FUNC_W-1:0] func,
    input  logic side,
    input  logic [TIME_W-1:0] now_ms,
    input  logic out_valid,
    input  logic out_stall,
    input  logic [CODE_W-1:0] event_code,
    input  logic left_held,
    input  logic right_held,
    input  logic last,
    output int mismatches,
    output int pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        event_t code;
        logic left_on;
        logic right_on;
        logic fin;
    } gesture_t;

    logic left_down_q;
    logic right_down_q;
    logic both_seen_q;
    logic timer_armed;
    logic [TIME_W-1:0] left_cue_ms;
    logic [TIME_W-1:0] right_cue_ms;
    logic [TIME_W-1:0] timer_start_ms;
    logic [CFG_W-1:0] hold_limit_ms;
    logic [CFG_W-1:0] cooldown_ms;

    event_t step_codes[$];
    gesture_t expected_gestures[$];

    // A zero stamp means no cue has been given yet on that side.
    task automatic cue_press(input logic is_left, input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] stamp;
        stamp = is_left ? left_cue_ms : right_cue_ms;
        if (stamp != '0 && TIME_W'(t - stamp) < TIME_W'(cooldown_ms))
            return;
        if (is_left)
            left_cue_ms = t;
        else
            right_cue_ms = t;
        step_codes.push_back(is_left ? EV_LPRESS : EV_RPRESS);
    endtask

    task automatic arm_hold_timer(input logic [TIME_W-1:0] t);
        if (!timer_armed)
        begin
            timer_armed = 1'b1;
            timer_start_ms = t;
        end
    endtask

    task automatic clear_on_release();
        timer_armed = 1'b0;
        if (!left_down_q && !right_down_q && both_seen_q)
            step_codes.push_back(EV_BOTH_UP);
        both_seen_q = 1'b0;
    endtask

    task automatic predict_gestures(input logic [FUNC_W-1:0] fn, input logic sd,
                                    input logic [TIME_W-1:0] t);
        logic is_left;
        gesture_t g;
        is_left = (sd == 1'b0);
        step_codes.delete();
        case (fn)
            FN_DOWN:
            begin
                if (is_left)
                begin
                    left_down_q = 1'b1;
                    step_codes.push_back(EV_LDOWN);
                end
                else
                begin
                    right_down_q = 1'b1;
                    step_codes.push_back(EV_RDOWN);
                end
                if (!(left_down_q && right_down_q))
                    cue_press(is_left, t);
                if (left_down_q && right_down_q)
                begin
                    if (!both_seen_q)
                    begin
                        step_codes.push_back(EV_BOTH_DOWN);
                        both_seen_q = 1'b1;
                    end
                    arm_hold_timer(t);
                end
                else
                begin
                    timer_armed = 1'b0;
                    both_seen_q = 1'b0;
                end
            end
            FN_UP:
            begin
                if (is_left)
                begin
                    left_down_q = 1'b0;
                    step_codes.push_back(EV_LUP);
                end
                else
                begin
                    right_down_q = 1'b0;
                    step_codes.push_back(EV_RUP);
                end
                clear_on_release();
            end
            FN_CLICK:
                cue_press(is_left, t);
            FN_LONG_START:
            begin
                // With the other button held a long press only arms the combined timer.
                if (is_left ? right_down_q : left_down_q)
                    arm_hold_timer(t);
                else
                    step_codes.push_back(is_left ? EV_LHOLD : EV_RHOLD);
            end
            FN_LONG_RELEASE:
            begin
                if (is_left)
                    left_down_q = 1'b0;
                else
                    right_down_q = 1'b0;
                clear_on_release();
            end
            FN_TIMER:
            begin
                if (timer_armed && TIME_W'(t - timer_start_ms) >= TIME_W'(hold_limit_ms))
                begin
                    timer_armed = 1'b0;
                    if (left_down_q && right_down_q && both_seen_q)
                        step_codes.push_back(EV_BOTH_HOLD);
                end
            end
            default:
                ;
        endcase
        foreach (step_codes[k])
        begin
            g.code = step_codes[k];
            g.left_on = left_down_q;
            g.right_on = right_down_q;
            g.fin = (k == step_codes.size() - 1);
            expected_gestures.push_back(g);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gesture_t want;
        if (!rst_n)
        begin
            left_down_q = 1'b0;
            right_down_q = 1'b0;
            both_seen_q = 1'b0;
            timer_armed = 1'b0;
            left_cue_ms = '0;
            right_cue_ms = '0;
            timer_start_ms = '0;
            hold_limit_ms = HOLD_THRESHOLD_RESET;
            cooldown_ms = CUE_COOLDOWN_RESET;
            expected_gestures.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_IDX_HOLD_THRESHOLD)
                    hold_limit_ms = cfg_data;
                else
                    cooldown_ms = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_gestures.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result code %0d L%0b R%0b last %0b",
                                 $time, event_code, left_held, right_held, last);
                end
                else
                begin
                    want = expected_gestures.pop_front();
                    if (event_code !== want.code || left_held !== want.left_on ||
                        right_held !== want.right_on || last !== want.fin)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected code %0d L%0b R%0b last %0b, got code %0d L%0b R%0b last %0b",
                                     $time, want.code, want.left_on, want.right_on, want.fin,
                                     event_code, left_held, right_held, last);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_gestures(func, side, now_ms);
            pending = expected_gestures.size();
        end
    end

endmodule

>>> tb/two_button_gesture_combiner_core_tb.sv
// Top of the gesture combiner testbench: clock, reset, configuration writes, request
// stimulus, receiver stalls, watchdog and verdict. Depends on tbgc_pkg, the core and
// gesture_checker.
module two_button_gesture_combiner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tbgc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int PRESSURE_AT = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 100;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [FUNC_W-1:0] func;
    logic side;
    logic [TIME_W-1:0] now_ms;
    logic out_valid;
    logic out_stall;
    logic [CODE_W-1:0] event_code;
    logic left_held;
    logic right_held;
    logic last;
    int mismatches;
    int pending;

    logic quiet;
    int unsigned requests_sent;
    int unsigned stuck_cycles;
    logic [TIME_W-1:0] wall_ms;

    two_button_gesture_combiner_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .side(side),
        .now_ms(now_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_code(event_code),
        .left_held(left_held),
        .right_held(right_held),
        .last(last)
    );

    gesture_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short steps of time, now and then long waits or a jump anywhere.
    function automatic logic [TIME_W-1:0] next_time();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            wall_ms += $urandom_range(400);
        else if (r < 95)
            wall_ms += $urandom_range(3000);
        else if (r < 98)
            wall_ms += $urandom_range(70000);
        else
            wall_ms = $urandom();
        return wall_ms;
    endfunction

    task automatic send(input logic [FUNC_W-1:0] fn, input logic sd,
                        input logic [TIME_W-1:0] t);
        while (!quiet && $urandom_range(99) < 38)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        func = fn;
        side = sd;
        now_ms = t;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        requests_sent++;
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
    endtask

    // Let every expected result drain, then allow for requests that give no result.
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_gesture(input int unsigned kind);
        logic a;
        logic b;
        a = 1'($urandom_range(1));
        b = !a;
        case (kind)
            0:
            begin
                send(FN_DOWN, a, next_time());
                repeat ($urandom_range(2)) send(FN_CLICK, a, next_time());
                send(FN_UP, a, next_time());
            end
            1:
            begin
                send(FN_DOWN, a, next_time());
                send(FN_DOWN, b, next_time());
                if ($urandom_range(1))
                    send(FN_LONG_START, 1'($urandom_range(1)), next_time());
                repeat ($urandom_range(1, 4)) send(FN_TIMER, 1'($urandom_range(1)), next_time());
                send($urandom_range(1) ? FN_UP : FN_LONG_RELEASE, a, next_time());
                send(FN_UP, b, next_time());
            end
            2:
            begin
                send(FN_DOWN, a, next_time());
                send(FN_LONG_START, a, next_time());
                if ($urandom_range(1))
                    send(FN_TIMER, a, next_time());
                send($urandom_range(1) ? FN_LONG_RELEASE : FN_UP, a, next_time());
            end
            3:
            begin
                repeat ($urandom_range(2, 5))
                begin
                    wall_ms += $urandom_range(500);
                    send(FN_CLICK, a, wall_ms);
                end
            end
            default:
                send(FUNC_W'($urandom_range(7)), 1'($urandom_range(1)),
                     $urandom_range(1) ? next_time() : $urandom());
        endcase
    endtask

    // Receiver: random stalls, one long hold-off so that the core backs up into its input.
    initial
    begin
        bit pressure_done;
        pressure_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && requests_sent >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                out_stall = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_stall = !quiet && ($urandom_range(99) < 38);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned phase_start;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_IDX_HOLD_THRESHOLD;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FN_DOWN;
        side = 1'b0;
        now_ms = '0;
        quiet = 1'b0;
        requests_sent = 0;
        wall_ms = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_cfg(CFG_IDX_HOLD_THRESHOLD, 16'd500);
        write_cfg(CFG_IDX_CUE_COOLDOWN, 16'd200);
        cfg_wr_en = 1'b0;

        // A cue at time zero leaves the stamp empty, so the next click cues again.
        send(FN_CLICK, 1'b0, 32'd0);
        send(FN_CLICK, 1'b0, 32'd10);
        send(FN_CLICK, 1'b0, 32'd100);
        // Cooldown measured across the wrap of the millisecond counter.
        send(FN_CLICK, 1'b1, 32'hFFFF_FFF0);
        send(FN_CLICK, 1'b1, 32'h0000_0050);
        send(FN_DOWN, 1'b0, 32'd1000);
        send(FN_DOWN, 1'b1, 32'd1100);
        send(FN_TIMER, 1'b0, 32'd1200);
        send(FN_LONG_START, 1'b0, 32'd1300);
        send(FN_TIMER, 1'b1, 32'd1600);
        send(FN_TIMER, 1'b0, 32'd1700);
        send(FN_UP, 1'b1, 32'd1800);
        send(FN_LONG_START, 1'b0, 32'd1900);
        send(FN_LONG_RELEASE, 1'b0, 32'd2000);
        send(FN_DOWN, 1'b1, 32'd2100);
        send(FN_LONG_START, 1'b1, 32'd2200);
        send(3'b110, 1'b1, 32'd2250);
        send(3'b111, 1'b0, 32'd2260);
        send(FN_DOWN, 1'b0, 32'd2300);
        send(FN_LONG_RELEASE, 1'b1, 32'd2400);
        send(FN_TIMER, 1'b1, 32'hFFFF_FFFF);
        send(FN_UP, 1'b0, 32'd2500);
        send(FN_TIMER, 1'b0, $urandom());
        settle();

        wall_ms = 32'd5000;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_cfg(CFG_IDX_HOLD_THRESHOLD, 16'd0);
                    write_cfg(CFG_IDX_CUE_COOLDOWN, 16'd0);
                end
                1:
                begin
                    write_cfg(CFG_IDX_HOLD_THRESHOLD, 16'hFFFF);
                    write_cfg(CFG_IDX_CUE_COOLDOWN, 16'hFFFF);
                end
                2:
                begin
                    write_cfg(CFG_IDX_HOLD_THRESHOLD, HOLD_THRESHOLD_RESET);
                    write_cfg(CFG_IDX_CUE_COOLDOWN, CUE_COOLDOWN_RESET);
                end
                default:
                begin
                    write_cfg(CFG_IDX_HOLD_THRESHOLD, CFG_W'($urandom_range(50, 3000)));
                    write_cfg(CFG_IDX_CUE_COOLDOWN, CFG_W'($urandom_range(0, 800)));
                end
            endcase
            cfg_wr_en = 1'b0;
            // One whole phase runs without gaps on either side.
            quiet = (phase == 2);
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_ITEMS)
                run_gesture($urandom_range(5));
            settle();
        end
        quiet = 1'b0;

        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
